// ===== hdl/bfp_pkg.sv =====
// Shared types for the bounded FIFO with purge: command codes, sequencer states, result control.
package bfp_pkg;

	typedef enum logic [1:0] {
		CMD_ENQ   = 2'd0,
		CMD_DEQ   = 2'd1,
		CMD_PURGE = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic fin;
		logic done;
	} res_ctl_t;

endpackage

// ===== hdl/bfp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/bfp_ctrl.sv =====
// Sequencer that appends on enqueue and walks the slot RAM one entry a cycle for dequeue and purge.
module bfp_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  bfp_pkg::cmd_t                        cmd,
	input  logic [ID_WIDTH-1:0]                  proc_in,
	output logic                                 busy,
	output bfp_pkg::res_ctl_t                    res_ctl,
	output logic [ID_WIDTH-1:0]                  res_got,
	output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   res_fill
);

	import bfp_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [CW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       fill_q, fill_d;
	logic [ID_WIDTH-1:0] got_q, got_d;
	logic                done_q, done_d;

	logic                wr_en, rd_en;
	logic [AW-1:0]       wr_addr, rd_addr;
	logic [ID_WIDTH-1:0] wr_data, rd_data;

	logic                accept, id_nz, can_enq, start_walk, hit, more1, more2;
	logic [CW-1:0]       idx_nx1, idx_nx2;

	bfp_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign id_nz      = (proc_in != '0);
	assign can_enq    = id_nz && (fill_q < CW'(QUEUE_DEPTH));
	assign start_walk = accept && (fill_q != '0) &&
	                    ((cmd == CMD_DEQ) || ((cmd == CMD_PURGE) && id_nz));
	assign idx_nx1    = idx_q + CW'(1);
	assign idx_nx2    = idx_q + CW'(2);
	assign more1      = (idx_nx1 < fill_q);
	assign more2      = (idx_nx2 < fill_q);
	// The one comparator: a dequeue takes the head, a purge needs a matching identifier.
	assign hit        = (cmd_q == CMD_DEQ) || (rd_data == id_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_walk) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				state_d = more1 ? (hit ? ST_SHIFT : ST_SCAN) : ST_IDLE;
			end
			ST_SHIFT: begin
				state_d = more2 ? ST_SHIFT : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = fill_q[AW-1:0];
		wr_data      = proc_in;
		rd_en        = 1'b0;
		rd_addr      = '0;
		res_ctl.fin  = 1'b0;
		res_ctl.done = 1'b0;
		got_d        = got_q;
		done_d       = done_q;
		fill_d       = fill_q;
		idx_d        = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					got_d  = '0;
					done_d = 1'b0;
					idx_d  = '0;
					if (start_walk) begin
						rd_en   = 1'b1;
						rd_addr = '0;
					end else begin
						res_ctl.fin = 1'b1;
						if ((cmd == CMD_ENQ) && can_enq) begin
							wr_en        = 1'b1;
							fill_d       = fill_q + CW'(1);
							res_ctl.done = 1'b1;
						end
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					got_d  = rd_data;
					done_d = 1'b1;
					if (more1) begin
						// Keep idx_q on the gap and fetch its successor.
						rd_en   = 1'b1;
						rd_addr = idx_nx1[AW-1:0];
					end else begin
						fill_d       = fill_q - CW'(1);
						res_ctl.fin  = 1'b1;
						res_ctl.done = 1'b1;
					end
				end else if (more1) begin
					rd_en   = 1'b1;
					rd_addr = idx_nx1[AW-1:0];
					idx_d   = idx_nx1;
				end else begin
					res_ctl.fin = 1'b1;
				end
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_data;
				idx_d   = idx_nx1;
				if (more2) begin
					rd_en   = 1'b1;
					rd_addr = idx_nx2[AW-1:0];
				end else begin
					fill_d       = fill_q - CW'(1);
					res_ctl.fin  = 1'b1;
					res_ctl.done = done_q;
				end
			end
			default: begin
				res_ctl.fin = 1'b0;
			end
		endcase
	end

	assign res_got  = got_d;
	assign res_fill = fill_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			id_q  <= proc_in;
		end
		idx_q  <= idx_d;
		got_q  <= got_d;
		done_q <= done_d;
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SHIFT) |-> (idx_q < fill_q))
		else $error("walk index outside the held entries");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_ENQ && can_enq) |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("stored enqueue did not grow the queue");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && res_ctl.fin && res_ctl.done) |=> ((fill_q + CW'(1)) == $past(fill_q)))
		else $error("successful removal did not shrink the queue");

	a_walk_no_enq: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cmd_q == CMD_DEQ || cmd_q == CMD_PURGE))
		else $error("walk running for a command that needs none");
`endif

endmodule

// ===== hdl/bounded_fifo_with_purge_unit.sv =====
// Top level of the bounded FIFO with purge: sequencer, slot RAM and result register.
//
// Usage: a transaction is accepted at a rising edge where start is high and busy is low;
// cmd selects enqueue at the tail, dequeue of the head or purge of the first entry equal to
// proc_in. Identifier zero is never stored and never found; an enqueue into a full queue is
// dropped. Every accepted transaction yields exactly one result: strobe is high for one
// cycle with done_res, proc_out, count and is_empty, and the receiver cannot hold it off.
//
// Timing: an enqueue, and any transaction that needs no walk, completes in the cycle of acceptance; its result
// appears in the following cycle and busy does not rise. A dequeue or purge walks the slot
// RAM through its single read port, one slot per cycle, moving later entries forward over
// the removed one; busy stays high until the walk reaches the last held entry, and the result
// strobe rises in the same cycle that busy falls.
//
// Reset (arst_n low) empties the queue at once; slot contents are not cleared since only
// slots below the fill count are ever read.
module bounded_fifo_with_purge_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         cmd,
	input  logic [ID_WIDTH-1:0]                proc_in,
	output logic                               strobe,
	output logic                               done_res,
	output logic [ID_WIDTH-1:0]                proc_out,
	output logic [$clog2(QUEUE_DEPTH + 1)-1:0] count,
	output logic                               is_empty
);

	import bfp_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	res_ctl_t            res_ctl;
	logic [ID_WIDTH-1:0] res_got;
	logic [CW-1:0]       res_fill;

	logic                strobe_q, done_q;
	logic [ID_WIDTH-1:0] proc_out_q;
	logic [CW-1:0]       count_q;

	bfp_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH   (ID_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd_t'(cmd)),
		.proc_in (proc_in),
		.busy    (busy),
		.res_ctl (res_ctl),
		.res_got (res_got),
		.res_fill(res_fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_ctl.fin;
		end
	end

	// Payload is captured only when a transaction finishes, so it holds between results.
	always_ff @(posedge clk) begin
		if (res_ctl.fin) begin
			done_q     <= res_ctl.done;
			proc_out_q <= res_got;
			count_q    <= res_fill;
		end
	end

	assign strobe   = strobe_q;
	assign done_res = done_q;
	assign proc_out = proc_out_q;
	assign count    = count_q;
	assign is_empty = (count_q == '0);

endmodule
